// ===== design/spcol_pkg.sv =====
`default_nettype none
package spcol_pkg;

	// fixed-point and field widths
	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 32;
	localparam int BOX_W     = 31;
	localparam int DS_W      = 32;
	localparam int TIME_W    = 48;
	localparam int WIDE_W    = 64;
	localparam int HALF_W    = WIDE_W / 2;
	localparam int PROD_W    = 2 * WIDE_W;
	localparam int NUM_W     = WIDE_W + 1;

	// bits retired per stage in the iterative units
	localparam int STEPS       = 2;
	localparam int WRAP_STAGES = POS_W / STEPS;
	localparam int WRAP_LAT    = WRAP_STAGES + 1;
	localparam int SQRT_STAGES = WIDE_W / STEPS;
	localparam int DIV_STAGES  = TIME_W / STEPS;

	localparam logic [BOX_W-1:0]  BOX_RESET = BOX_W'(655360);
	localparam logic [POS_W-1:0]  BOX_ZERO_LEN = POS_W'(64'h8000_0000);
	localparam logic [TIME_W-1:0] TIME_MAX  = '1;

endpackage
`default_nettype wire

// ===== design/spcol_if.sv =====
`default_nettype none
interface spcol_req_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [spcol_pkg::POS_W-1:0]     rel_pos_x;
	logic signed [spcol_pkg::POS_W-1:0]     rel_pos_y;
	logic signed [spcol_pkg::POS_W-1:0]     rel_pos_z;
	logic signed [spcol_pkg::POS_W-1:0]     rel_vel_x;
	logic signed [spcol_pkg::POS_W-1:0]     rel_vel_y;
	logic signed [spcol_pkg::POS_W-1:0]     rel_vel_z;
	logic        [spcol_pkg::DS_W-1:0]      diameter_sum;
	logic        [spcol_pkg::TIME_W-1:0]    sim_time;

	modport source (output valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y,
		rel_vel_z, diameter_sum, sim_time, input ready);
	modport sink (input valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y,
		rel_vel_z, diameter_sum, sim_time, output ready);
endinterface

interface spcol_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              will_collide;
	logic [spcol_pkg::TIME_W-1:0]      event_time;

	modport source (output valid, will_collide, event_time, input ready);
	modport sink (input valid, will_collide, event_time, output ready);
endinterface

interface spcol_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [spcol_pkg::BOX_W-1:0]       data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/spcol_wrap.sv =====
`default_nettype none
module spcol_wrap (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [spcol_pkg::POS_W-1:0] pos,
	input  logic        [spcol_pkg::POS_W-1:0] len,
	output logic signed [spcol_pkg::POS_W-1:0] img
);
	localparam int W = spcol_pkg::POS_W;
	localparam int N = spcol_pkg::WRAP_STAGES;

	logic [W-1:0] rem_s [N];
	logic [W-1:0] dvd_s [N];
	logic         q_s   [N];
	logic         neg_s [N];
	logic [W-1:0] rem_nx [N];
	logic [W-1:0] dvd_nx [N];
	logic         q_nx   [N];
	logic [W-1:0] apos;
	logic signed [W-1:0] img_s;
	logic signed [W-1:0] img_nx;

	assign apos = pos[W-1] ? (~pos) + 1'b1 : pos;

	// restoring division |pos| / len, STEPS bits per stage; only remainder and quotient lsb kept
	always_comb begin
		logic [W-1:0] r;
		logic [W-1:0] dv;
		logic [W:0]   t;
		logic         q;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				r  = '0;
				dv = apos;
			end else begin
				r  = rem_s[k-1];
				dv = dvd_s[k-1];
			end
			q = 1'b0;
			for (int i = 0; i < spcol_pkg::STEPS; i++) begin
				t  = {r, dv[W-1]};
				dv = dv << 1;
				if (t >= {1'b0, len}) begin
					t = t - {1'b0, len};
					q = 1'b1;
				end else begin
					q = 1'b0;
				end
				r = t[W-1:0];
			end
			rem_nx[k] = r;
			dvd_nx[k] = dv;
			q_nx[k]   = q;
		end
	end

	// floor remainder from the magnitude result, then round half to even
	always_comb begin
		logic [W-1:0] r;
		logic         odd;
		logic [W:0]   tw;
		if (neg_s[N-1] && rem_s[N-1] != '0) begin
			r   = len - rem_s[N-1];
			odd = ~q_s[N-1];
		end else begin
			r   = rem_s[N-1];
			odd = q_s[N-1];
		end
		tw = {r, 1'b0};
		if (tw > {1'b0, len} || (tw == {1'b0, len} && odd)) begin
			img_nx = r - len;
		end else begin
			img_nx = r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_nx[k];
				dvd_s[k] <= dvd_nx[k];
				q_s[k]   <= q_nx[k];
				neg_s[k] <= (k == 0) ? pos[W-1] : neg_s[(k == 0) ? 0 : k-1];
			end
			img_s <= img_nx;
		end
	end

	assign img = img_s;
endmodule
`default_nettype wire

// ===== design/spcol_sqrt.sv =====
`default_nettype none
module spcol_sqrt (
	input  logic                              clk,
	input  logic                              en,
	input  logic [spcol_pkg::PROD_W-1:0]      rad,
	output logic [spcol_pkg::WIDE_W-1:0]      root
);
	localparam int W  = spcol_pkg::WIDE_W;
	localparam int DW = spcol_pkg::PROD_W;
	localparam int RW = W + 4;
	localparam int N  = spcol_pkg::SQRT_STAGES;

	logic [RW-1:0] rem_s [N];
	logic [W-1:0]  rt_s  [N];
	logic [DW-1:0] rd_s  [N];
	logic [RW-1:0] rem_nx [N];
	logic [W-1:0]  rt_nx  [N];
	logic [DW-1:0] rd_nx  [N];

	// digit-by-digit floor square root, two radicand bits per root bit
	always_comb begin
		logic [RW-1:0] r;
		logic [RW-1:0] tr;
		logic [W-1:0]  q;
		logic [DW-1:0] d;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				r = '0;
				q = '0;
				d = rad;
			end else begin
				r = rem_s[k-1];
				q = rt_s[k-1];
				d = rd_s[k-1];
			end
			for (int i = 0; i < spcol_pkg::STEPS; i++) begin
				r  = {r[RW-3:0], d[DW-1:DW-2]};
				d  = d << 2;
				tr = {2'b00, q, 2'b01};
				if (r >= tr) begin
					r = r - tr;
					q = {q[W-2:0], 1'b1};
				end else begin
					q = {q[W-2:0], 1'b0};
				end
			end
			rem_nx[k] = r;
			rt_nx[k]  = q;
			rd_nx[k]  = d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_nx[k];
				rt_s[k]  <= rt_nx[k];
				rd_s[k]  <= rd_nx[k];
			end
		end
	end

	assign root = rt_s[N-1];
endmodule
`default_nettype wire

// ===== design/sphere_pair_collision_time_top.sv =====
// Path: wrap stages, s1-s7, square-root stages, s8, s9, divider stages, s10.
// Throughput: one request per cycle while the output buffer is not full;
// box wrap, square root and time divider are unrolled, two bits per stage.
// A two-entry output buffer decouples rsp.ready from req.ready.
// Reset (arst_n low, async): all valid bits clear, box_length returns to 10.0.
`default_nettype none
module sphere_pair_collision_time_top (
	input  logic         clk,
	input  logic         arst_n,
	spcol_req_if.sink    req,
	spcol_rsp_if.source  rsp,
	spcol_cfg_if.sink    cfg
);
	localparam int PW  = spcol_pkg::POS_W;
	localparam int WW  = spcol_pkg::WIDE_W;
	localparam int HW  = spcol_pkg::HALF_W;
	localparam int XW  = spcol_pkg::PROD_W;
	localparam int TW  = spcol_pkg::TIME_W;
	localparam int NW  = spcol_pkg::NUM_W;
	localparam int FB  = spcol_pkg::FRAC_BITS;
	localparam int WL  = spcol_pkg::WRAP_LAT;
	localparam int SQN = spcol_pkg::SQRT_STAGES;
	localparam int DVN = spcol_pkg::DIV_STAGES;

	typedef struct packed {
		logic signed [PW-1:0] vx;
		logic signed [PW-1:0] vy;
		logic signed [PW-1:0] vz;
		logic [spcol_pkg::DS_W-1:0] ds;
		logic [TW-1:0] tnow;
	} wsb_t;

	typedef struct packed {
		logic          kill;
		logic          bneg;
		logic [WW-1:0] bm;
		logic [WW-1:0] a;
		logic [TW-1:0] tnow;
	} qsb_t;

	typedef struct packed {
		logic          kill;
		logic          sat;
		logic [TW-1:0] tnow;
		logic [WW-1:0] a;
		logic [WW-1:0] rem;
		logic [TW-1:0] low;
		logic [TW-1:0] quo;
	} dv_t;

	typedef struct packed {
		logic          will_collide;
		logic [TW-1:0] event_time;
	} res_t;

	// ---------------------------------------------------------------
	// Global advance. The whole pipe moves together; it stops only when
	// the output buffer holds two results.
	// ---------------------------------------------------------------
	logic en;
	logic e0_q, e1_q;

	assign en        = ~e1_q;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	// box side register; zero means a side of 2^31
	logic [spcol_pkg::BOX_W-1:0] box_q;
	logic [PW-1:0]               len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= spcol_pkg::BOX_RESET;
		end else if (cfg.valid) begin
			box_q <= cfg.data;
		end
	end

	assign len = (box_q == '0) ? spcol_pkg::BOX_ZERO_LEN : {1'b0, box_q};

	// ---------------------------------------------------------------
	// Minimum-image wrap, one unit per axis. Velocity, diameter sum and
	// time ride alongside in a delay line of the same length.
	// ---------------------------------------------------------------
	logic signed [PW-1:0] pos_in [3];
	logic signed [PW-1:0] img    [3];

	assign pos_in[0] = req.rel_pos_x;
	assign pos_in[1] = req.rel_pos_y;
	assign pos_in[2] = req.rel_pos_z;

	for (genvar g = 0; g < 3; g++) begin : g_wrap
		spcol_wrap u_wrap (
			.clk (clk),
			.en  (en),
			.pos (pos_in[g]),
			.len (len),
			.img (img[g])
		);
	end

	wsb_t          wsb_s [WL];
	logic [WL-1:0] wv_s;

	always_ff @(posedge clk) begin
		if (en) begin
			wsb_s[0] <= '{vx: req.rel_vel_x, vy: req.rel_vel_y, vz: req.rel_vel_z,
				ds: req.diameter_sum, tnow: req.sim_time};
			for (int k = 1; k < WL; k++) begin
				wsb_s[k] <= wsb_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_s <= '0;
		end else if (en) begin
			wv_s <= {wv_s[WL-2:0], req.valid};
		end
	end

	logic signed [PW-1:0] vel [3];
	assign vel[0] = wsb_s[WL-1].vx;
	assign vel[1] = wsb_s[WL-1].vy;
	assign vel[2] = wsb_s[WL-1].vz;

	// ---------------------------------------------------------------
	// s1: per-axis products, s2: dot products, s3: C sign and |b|
	// ---------------------------------------------------------------
	logic signed [WW-1:0] vv_s1 [3];
	logic signed [WW-1:0] vp_s1 [3];
	logic signed [WW-1:0] pp_s1 [3];
	logic [WW-1:0]        ds2_s1;
	logic [TW-1:0]        tnow_s1;

	logic [WW-1:0]        a_s2;
	logic signed [WW-1:0] b_s2;
	logic [WW-1:0]        p4_s2;
	logic [WW-1:0]        ds2_s2;
	logic [TW-1:0]        tnow_s2;

	logic                 cpos_s3, bneg_s3, kill_s3;
	logic [WW-1:0]        cmag_s3, bm_s3, a_s3;
	logic [TW-1:0]        tnow_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vv_s1[i] <= vel[i] * vel[i];
				vp_s1[i] <= vel[i] * img[i];
				pp_s1[i] <= img[i] * img[i];
			end
			ds2_s1  <= WW'(wsb_s[WL-1].ds) * WW'(wsb_s[WL-1].ds);
			tnow_s1 <= wsb_s[WL-1].tnow;

			a_s2    <= vv_s1[0] + vv_s1[1] + vv_s1[2];
			b_s2    <= vp_s1[0] + vp_s1[1] + vp_s1[2];
			p4_s2   <= (pp_s1[0] + pp_s1[1] + pp_s1[2]) << 2;
			ds2_s2  <= ds2_s1;
			tnow_s2 <= tnow_s1;

			cpos_s3 <= p4_s2 > ds2_s2;
			cmag_s3 <= (p4_s2 > ds2_s2) ? p4_s2 - ds2_s2 : ds2_s2 - p4_s2;
			bneg_s3 <= b_s2[WW-1];
			bm_s3   <= b_s2[WW-1] ? (~b_s2) + 1'b1 : b_s2;
			a_s3    <= a_s2;
			kill_s3 <= a_s2 == '0;   // no relative motion
			tnow_s3 <= tnow_s2;
		end
	end

	// ---------------------------------------------------------------
	// s4: 32x32 partial products of b^2 and A*|C|, s5: assemble them
	// ---------------------------------------------------------------
	logic [WW-1:0] yll_s4, ym_s4, yhh_s4;
	logic [WW-1:0] xll_s4, xm1_s4, xm2_s4, xhh_s4;
	logic          cpos_s4, bneg_s4, kill_s4;
	logic [WW-1:0] bm_s4, a_s4;
	logic [TW-1:0] tnow_s4;

	logic [XW-1:0] y_s5, x_s5;
	logic          cpos_s5, bneg_s5, kill_s5;
	logic [WW-1:0] bm_s5, a_s5;
	logic [TW-1:0] tnow_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			yll_s4  <= WW'(bm_s3[HW-1:0])  * WW'(bm_s3[HW-1:0]);
			ym_s4   <= WW'(bm_s3[HW-1:0])  * WW'(bm_s3[WW-1:HW]);
			yhh_s4  <= WW'(bm_s3[WW-1:HW]) * WW'(bm_s3[WW-1:HW]);
			xll_s4  <= WW'(a_s3[HW-1:0])   * WW'(cmag_s3[HW-1:0]);
			xm1_s4  <= WW'(a_s3[HW-1:0])   * WW'(cmag_s3[WW-1:HW]);
			xm2_s4  <= WW'(a_s3[WW-1:HW])  * WW'(cmag_s3[HW-1:0]);
			xhh_s4  <= WW'(a_s3[WW-1:HW])  * WW'(cmag_s3[WW-1:HW]);
			cpos_s4 <= cpos_s3;
			bneg_s4 <= bneg_s3;
			kill_s4 <= kill_s3;
			bm_s4   <= bm_s3;
			a_s4    <= a_s3;
			tnow_s4 <= tnow_s3;

			// cross term of b^2 appears twice
			y_s5    <= {yhh_s4, yll_s4} + (XW'(ym_s4) << (HW + 1));
			x_s5    <= {xhh_s4, xll_s4} + (XW'(xm1_s4) << HW) + (XW'(xm2_s4) << HW);
			cpos_s5 <= cpos_s4;
			bneg_s5 <= bneg_s4;
			kill_s5 <= kill_s4;
			bm_s5   <= bm_s4;
			a_s5    <= a_s4;
			tnow_s5 <= tnow_s4;
		end
	end

	// ---------------------------------------------------------------
	// s6: A*C/4, rounded up when C > 0. s7: discriminant and its sign.
	// ---------------------------------------------------------------
	logic [XW:0]   x3;
	logic [XW-1:0] xc_s6, y_s6;
	logic          cpos_s6, bneg_s6, kill_s6;
	logic [WW-1:0] bm_s6, a_s6;
	logic [TW-1:0] tnow_s6;

	assign x3 = {1'b0, x_s5} + (XW + 1)'(3);

	logic [XW:0]   diff;
	logic [XW-1:0] dsum;
	logic [XW-1:0] d_s7;
	qsb_t          qsb7_s7;

	assign diff = {1'b0, y_s6} - {1'b0, xc_s6};
	assign dsum = y_s6 + xc_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s6   <= cpos_s5 ? XW'(x3[XW:2]) : (x_s5 >> 2);
			y_s6    <= y_s5;
			cpos_s6 <= cpos_s5;
			bneg_s6 <= bneg_s5;
			kill_s6 <= kill_s5;
			bm_s6   <= bm_s5;
			a_s6    <= a_s5;
			tnow_s6 <= tnow_s5;

			d_s7         <= cpos_s6 ? diff[XW-1:0] : dsum;
			qsb7_s7.kill <= kill_s6 |
				(cpos_s6 ? (diff[XW] || diff == '0) : (dsum == '0));
			qsb7_s7.bneg <= bneg_s6;
			qsb7_s7.bm   <= bm_s6;
			qsb7_s7.a    <= a_s6;
			qsb7_s7.tnow <= tnow_s6;
		end
	end

	// ---------------------------------------------------------------
	// Square root of the discriminant, sideband delayed to match.
	// ---------------------------------------------------------------
	logic [WW-1:0]  root;
	qsb_t           qsb_s [SQN];

	spcol_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (d_s7),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			qsb_s[0] <= qsb7_s7;
			for (int k = 1; k < SQN; k++) begin
				qsb_s[k] <= qsb_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// s8: root choice. b >= 0 needs s > |b|; b < 0 takes |b|-s, or
	// |b|+s when the small root is negative; a zero small root is no hit.
	// ---------------------------------------------------------------
	qsb_t          qo;
	logic [NW-1:0] sub_sb, sub_bs, add_bs;
	logic [NW-1:0] num_nx;
	logic          kill_nx;

	assign qo     = qsb_s[SQN-1];
	assign sub_sb = {1'b0, root} - {1'b0, qo.bm};
	assign sub_bs = {1'b0, qo.bm} - {1'b0, root};
	assign add_bs = {1'b0, qo.bm} + {1'b0, root};

	always_comb begin
		kill_nx = qo.kill;
		num_nx  = add_bs;
		if (!qo.bneg) begin
			num_nx = {1'b0, sub_sb[WW-1:0]};
			if (sub_sb[NW-1] || sub_sb == '0) begin
				kill_nx = 1'b1;
			end
		end else if (!sub_bs[NW-1] && sub_bs != '0) begin
			num_nx = {1'b0, sub_bs[WW-1:0]};
		end else if (sub_bs == '0) begin
			kill_nx = 1'b1;
		end
	end

	logic [NW-1:0] num_s8;
	logic          kill_s8;
	logic [WW-1:0] a_s8;
	logic [TW-1:0] tnow_s8;

	// s9: saturation test and divider seed; quotient overflows 48 bits
	// exactly when the top part of num << FRAC_BITS reaches A
	logic [WW-1:0] hi9;
	dv_t           dv0_s9;

	assign hi9 = WW'(num_s8[NW-1:TW-FB]);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s8  <= num_nx;
			kill_s8 <= kill_nx;
			a_s8    <= qo.a;
			tnow_s8 <= qo.tnow;

			dv0_s9.kill <= kill_s8;
			dv0_s9.sat  <= hi9 >= a_s8;
			dv0_s9.tnow <= tnow_s8;
			dv0_s9.a    <= a_s8;
			dv0_s9.rem  <= hi9;
			dv0_s9.low  <= {num_s8[TW-FB-1:0], {FB{1'b0}}};
			dv0_s9.quo  <= '0;
		end
	end

	// ---------------------------------------------------------------
	// Time divider: restoring, 48 quotient bits, STEPS per stage.
	// ---------------------------------------------------------------
	dv_t dv_s  [DVN];
	dv_t dv_nx [DVN];

	always_comb begin
		dv_t       cur;
		logic [WW:0] t;
		logic      q;
		for (int k = 0; k < DVN; k++) begin
			cur = (k == 0) ? dv0_s9 : dv_s[(k == 0) ? 0 : k-1];
			for (int i = 0; i < spcol_pkg::STEPS; i++) begin
				t       = {cur.rem, cur.low[TW-1]};
				cur.low = cur.low << 1;
				if (t >= {1'b0, cur.a}) begin
					t = t - {1'b0, cur.a};
					q = 1'b1;
				end else begin
					q = 1'b0;
				end
				cur.rem = t[WW-1:0];
				cur.quo = {cur.quo[TW-2:0], q};
			end
			dv_nx[k] = cur;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DVN; k++) begin
				dv_s[k] <= dv_nx[k];
			end
		end
	end

	// ---------------------------------------------------------------
	// s10: relative time (zero means "now", no hit) plus sim_time,
	// saturating at the top of the 48-bit range.
	// ---------------------------------------------------------------
	dv_t           dl;
	logic [TW-1:0] trel;
	logic [TW:0]   tabs;
	logic          hit;
	res_t          res_nx;
	res_t          res_s10;

	assign dl   = dv_s[DVN-1];
	assign trel = dl.sat ? spcol_pkg::TIME_MAX : dl.quo;
	assign tabs = {1'b0, dl.tnow} + {1'b0, trel};
	assign hit  = !dl.kill && trel != '0;

	always_comb begin
		res_nx.will_collide = hit;
		if (!hit) begin
			res_nx.event_time = '0;
		end else if (tabs[TW]) begin
			res_nx.event_time = spcol_pkg::TIME_MAX;
		end else begin
			res_nx.event_time = tabs[TW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s10 <= res_nx;
		end
	end

	// valid bits for the single-register stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [SQN-1:0] qv_s;
	logic [DVN-1:0] dvv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			qv_s  <= '0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			dvv_s <= '0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= wv_s[WL-1];
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			qv_s  <= {qv_s[SQN-2:0], v_s7};
			v_s8  <= qv_s[SQN-1];
			v_s9  <= v_s8;
			dvv_s <= {dvv_s[DVN-2:0], v_s9};
			v_s10 <= dvv_s[DVN-1];
		end
	end

	// ---------------------------------------------------------------
	// Output buffer: entry 0 drives rsp, entry 1 catches the result that
	// arrives while entry 0 is stalled.
	// ---------------------------------------------------------------
	logic push, pop;
	res_t d0_q, d1_q;

	assign push = en && v_s10;
	assign pop  = e0_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_q <= 1'b0;
			e1_q <= 1'b0;
		end else if (!e0_q) begin
			e0_q <= push;
		end else if (!e1_q) begin
			if (push && !pop) begin
				e1_q <= 1'b1;
			end else if (!push && pop) begin
				e0_q <= 1'b0;
			end
		end else if (pop) begin
			e1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!e0_q || (!e1_q && pop)) begin
			if (push) begin
				d0_q <= res_s10;
			end
		end else if (!e1_q) begin
			if (push) begin
				d1_q <= res_s10;
			end
		end else if (pop) begin
			d0_q <= d1_q;
		end
	end

	assign rsp.valid        = e0_q;
	assign rsp.will_collide = d0_q.will_collide;
	assign rsp.event_time   = d0_q.event_time;
endmodule
`default_nettype wire

// ===== design/spcol_chk.sv =====
`default_nettype none
module spcol_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_will_collide,
	input logic [spcol_pkg::TIME_W-1:0]  rsp_event_time
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_time)
			&& $stable(rsp_will_collide))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_will_collide |-> rsp_event_time == '0)
		else $error("event_time nonzero without collision");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_will_collide |-> rsp_event_time != '0)
		else $error("collision reported at time zero");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
		else $error("request side stalled without a stalled result");
endmodule

bind sphere_pair_collision_time_top spcol_chk u_spcol_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_will_collide (rsp.will_collide),
	.rsp_event_time   (rsp.event_time)
);
`default_nettype wire

// ===== tb/sv/collision_checker.sv =====
`default_nettype none
module collision_checker (
	input  logic        clk,
	input  logic        arst_n,
	spcol_req_if        req,
	spcol_rsp_if        rsp,
	spcol_cfg_if        cfg,
	output int          fail_count,
	output int          pending,
	output int          hits_seen,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] TIME_SAT = 64'(spcol_pkg::TIME_MAX);

	typedef struct packed {
		logic                         will_collide;
		logic [spcol_pkg::TIME_W-1:0] event_time;
	} contact_t;

	logic [spcol_pkg::BOX_W-1:0] box_len;
	contact_t                    expected_contacts[$];

	// minimum-image wrap, ties go to the even image count
	function automatic longint wrap_image(input longint p, input longint len);
		longint r;
		longint k;
		r = p % len;
		if (r < 0) r += len;
		k = (p - r) / len;
		if (2 * r > len || (2 * r == len && k[0])) return r - len;
		return r;
	endfunction

	// relative contact time in Q.FRAC_BITS, 0 for no contact
	function automatic logic [63:0] contact_offset(input logic [spcol_pkg::BOX_W-1:0] box,
			input longint pos[3], input longint vel[3],
			input logic [spcol_pkg::DS_W-1:0] ds);
		longint       len, p, v, b;
		logic [63:0]  a, p2, ds2, p4, cmag, bm, s, c;
		logic [127:0] y, x, xc, d, num, q;
		logic         cpos;
		len = (box == 0) ? longint'(spcol_pkg::BOX_ZERO_LEN) : longint'(box);
		a = 0; b = 0; p2 = 0;
		for (int i = 0; i < 3; i++) begin
			p = wrap_image(pos[i], len);
			v = vel[i];
			a += 64'(v * v);
			b += v * p;
			p2 += 64'(p * p);
		end
		if (a == 0) return 0;
		ds2 = 64'(ds) * 64'(ds);
		p4 = p2 << 2;
		cpos = p4 > ds2;
		cmag = cpos ? p4 - ds2 : ds2 - p4;
		bm = (b < 0) ? 64'(-b) : 64'(b);
		y = 128'(bm) * 128'(bm);
		x = 128'(a) * 128'(cmag);
		if (cpos) begin
			// A*C rounded up so the discriminant rounds down
			xc = (x + 128'd3) >> 2;
			if (y <= xc) return 0;
			d = y - xc;
		end else begin
			d = y + (x >> 2);
		end
		if (d == 0) return 0;
		s = 0;
		for (int i = 63; i >= 0; i--) begin
			c = s | (64'd1 << i);
			if (128'(c) * 128'(c) <= d) s = c;
		end
		if (b >= 0) begin
			if (s <= bm) return 0;
			num = 128'(s - bm);
		end else if (bm > s) begin
			num = 128'(bm - s);
		end else if (bm == s) begin
			return 0;
		end else begin
			num = 128'(bm) + 128'(s);
		end
		q = (num << spcol_pkg::FRAC_BITS) / 128'(a);
		if (q > 128'(TIME_SAT)) return TIME_SAT;
		return q[63:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint      pos[3];
		longint      vel[3];
		logic [63:0] t, sum;
		contact_t    c;
		if (!arst_n) begin
			box_len = spcol_pkg::BOX_RESET;
		end else begin
			if (cfg.valid && cfg.ready) box_len = cfg.data;
			if (req.valid && req.ready) begin
				pos[0] = longint'(req.rel_pos_x);
				pos[1] = longint'(req.rel_pos_y);
				pos[2] = longint'(req.rel_pos_z);
				vel[0] = longint'(req.rel_vel_x);
				vel[1] = longint'(req.rel_vel_y);
				vel[2] = longint'(req.rel_vel_z);
				t = contact_offset(box_len, pos, vel, req.diameter_sum);
				if (t == 0) begin
					c = '0;
				end else begin
					sum = 64'(req.sim_time) + t;
					c.will_collide = 1'b1;
					c.event_time = (sum > TIME_SAT) ? spcol_pkg::TIME_MAX :
						sum[spcol_pkg::TIME_W-1:0];
				end
				expected_contacts.push_back(c);
				pending++;
			end
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (rsp.will_collide === 1'b1) hits_seen++;
				if (expected_contacts.size() == 0) begin
					report_mismatch("unexpected result", rsp.event_time, 0);
				end else begin
					c = expected_contacts.pop_front();
					pending--;
					if (rsp.will_collide !== c.will_collide)
						report_mismatch("will_collide", rsp.will_collide, c.will_collide);
					if (rsp.event_time !== c.event_time)
						report_mismatch("event_time", rsp.event_time, c.event_time);
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
		hits_seen = 0;
		results_seen = 0;
	end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 100;    // longer than the block latency
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	int   cycles;
	int   fail_count, pending, hits_seen, results_seen;

	// idle draws are forced to zero during quiet stretches
	bit   quiet_req, quiet_rsp;
	bit   long_hold;

	spcol_req_if req ();
	spcol_rsp_if rsp ();
	spcol_cfg_if cfg ();

	sphere_pair_collision_time_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	collision_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.cfg          (cfg),
		.fail_count   (fail_count),
		.pending      (pending),
		.hits_seen    (hits_seen),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hang anywhere ends the run as a failure
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// response side: random ready delay per result, plus one long hold
	initial begin
		int w;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 0;
			end else begin
				w = quiet_rsp ? 0 : $urandom_range(0, 18);
				if (w > 0) begin
					rsp.ready <= 1'b0;
					repeat (w) @(negedge clk);
				end
				rsp.ready <= 1'b1;
				do @(posedge clk); while (!(rsp.valid && rsp.ready) && !long_hold);
				@(negedge clk);
			end
		end
	end

	// one request; gap drawn before it unless in a quiet stretch
	task automatic send_pair(input logic [31:0] px, py, pz, vx, vy, vz,
			input logic [spcol_pkg::DS_W-1:0] ds, input logic [spcol_pkg::TIME_W-1:0] st);
		int gap;
		gap = quiet_req ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid        <= 1'b1;
		req.rel_pos_x    <= px;
		req.rel_pos_y    <= py;
		req.rel_pos_z    <= pz;
		req.rel_vel_x    <= vx;
		req.rel_vel_y    <= vy;
		req.rel_vel_z    <= vz;
		req.diameter_sum <= ds;
		req.sim_time     <= st;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// lower valid, let every result come back, then let the pipe empty
	task automatic drain_all();
		req.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_box(input logic [spcol_pkg::BOX_W-1:0] len);
		cfg.valid <= 1'b1;
		cfg.data  <= len;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	// mostly approaching pairs: small offsets, velocity roughly against the offset
	task automatic send_random_pair();
		logic [31:0] p[3], v[3];
		logic [spcol_pkg::DS_W-1:0] ds;
		logic [spcol_pkg::TIME_W-1:0] st;
		int sh, k;
		if ($urandom_range(0, 3) == 0) begin
			// noise: every field fully random
			send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, rand48());
			return;
		end
		sh = $urandom_range(6, 20);
		for (int i = 0; i < 3; i++) begin
			p[i] = $signed($urandom) >>> sh;
			k = $urandom_range(0, 6);
			v[i] = -($signed(p[i]) >>> k) + ($signed($urandom) >>> $urandom_range(12, 31));
		end
		ds = $urandom >> $urandom_range(sh - 2, 31);
		case ($urandom_range(0, 3))
			0: st = '1 - 48'($urandom_range(0, 1 << 20));
			1: st = 48'($urandom);
			default: st = rand48();
		endcase
		send_pair(p[0], p[1], p[2], v[0], v[1], v[2], ds, st);
	endtask

	task automatic random_phase(input int count);
		for (int n = 0; n < count; n++) begin
			// redraw busy or quiet stretches every 40 requests
			if (n % 40 == 0) begin
				quiet_req = ($urandom_range(0, 3) == 0);
				quiet_rsp = ($urandom_range(0, 3) == 0);
			end
			send_random_pair();
		end
		quiet_req = 0;
		quiet_rsp = 0;
	endtask

	initial begin
		logic [31:0] half;
		req.valid = 1'b0;
		req.rel_pos_x = '0;
		req.rel_pos_y = '0;
		req.rel_pos_z = '0;
		req.rel_vel_x = '0;
		req.rel_vel_y = '0;
		req.rel_vel_z = '0;
		req.diameter_sum = '0;
		req.sim_time = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		quiet_req = 0;
		quiet_rsp = 0;
		long_hold = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset box of 10.0
		// head-on: gap 2.0 closing at 1.0, contact at 1.5
		send_pair(32'sd131072, 0, 0, -32'sd65536, 0, 0, 32'd65536, 48'd0);
		// receding pair
		send_pair(32'sd131072, 0, 0, 32'sd65536, 0, 0, 32'd65536, 48'd100);
		// no relative motion
		send_pair(32'sd131072, 0, 0, 0, 0, 0, 32'd65536, 48'd5);
		// already overlapping, moving apart gives the large root
		send_pair(32'sd16384, 0, 0, 32'sd65536, 0, 0, 32'd131072, 48'd7);
		// grazing miss, offset perpendicular to motion
		send_pair(32'sd131072, 32'sd262144, 0, -32'sd65536, 0, 0, 32'd65536, 48'd0);
		// exact half-box ties: 5.0 and 15.0 and -5.0
		send_pair(32'sd327680, 0, 0, -32'sd65536, 0, 0, 32'd65536, 48'd0);
		send_pair(32'sd983040, 0, 0, -32'sd65536, 0, 0, 32'd65536, 48'd0);
		send_pair(-32'sd327680, 0, 0, 32'sd65536, 0, 0, 32'd65536, 48'd0);
		// touching exactly now: small root zero
		send_pair(32'sd32768, 0, 0, -32'sd65536, 0, 0, 32'd65536, 48'd0);
		// very fast approach: contact time barely above zero
		send_pair(32'sd131072, 0, 0, 32'h8000_0000, 0, 0, 32'd65536, 48'd0);
		// very slow approach: large time, then saturating sum
		send_pair(32'sd131072, 0, 0, -32'sd1, 0, 0, 32'd65536, 48'd0);
		send_pair(32'sd131072, 0, 0, -32'sd1, 0, 0, 32'd65536, '1);
		// field extremes
		send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, '1, '1);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, '0, '0);
		send_pair(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 0, '1,
			48'h8000_0000_0000);
		send_pair(0, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536, '1, 48'd1);
		drain_all();

		random_phase(150);

		// pressure: hold the result side while requests keep coming
		long_hold = 1;
		random_phase(60);
		drain_all();

		// smallest box: everything wraps to zero offset
		write_box(31'd1);
		send_pair(32'sd131072, 0, 0, -32'sd65536, 0, 0, 32'd65536, 48'd0);
		random_phase(60);
		drain_all();

		// largest box, then an offset just under half of it
		write_box('1);
		half = 32'h3fff_ffff;
		send_pair(half, 0, 0, -32'sd65536, 0, 0, 32'd65536, 48'd0);
		random_phase(100);
		drain_all();

		// zero box acts as 2^31, tie at 2^30
		write_box('0);
		send_pair(32'h4000_0000, 0, 0, -32'sd65536, 0, 0, 32'd65536, 48'd0);
		send_pair(32'hc000_0000, 0, 0, 32'sd65536, 0, 0, 32'd65536, 48'd0);
		random_phase(100);
		drain_all();

		// small even box of 2.0 with odd-multiple ties
		write_box(31'd131072);
		send_pair(32'sd65536, 32'sd196608, -32'sd65536, -32'sd4096, 0, 0, 32'd16384, 48'd0);
		random_phase(100);
		drain_all();

		// random mid-size box
		write_box(31'($urandom_range(65536, 32'h0100_0000)));
		random_phase(100);
		drain_all();

		// back to the reset value
		write_box(spcol_pkg::BOX_RESET);
		random_phase(50);
		drain_all();

		$display("covered %0d results, %0d contacts, box settings from 1 to max and zero",
			results_seen, hits_seen);
		$display("one long result-side hold and a full drain before every box change");
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
